FILE: rtl/dbfr_pkg.sv
`timescale 1ns / 1ps
// shared codes and types for the double-buffered frame readout
package dbfr_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned CUR_W  = 8;

  localparam logic [OP_W-1:0] OP_SET_OFFSET = 3'd0;
  localparam logic [OP_W-1:0] OP_READ       = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_ONE  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_TWO  = 3'd3;
  localparam logic [OP_W-1:0] OP_PUBLISH    = 3'd4;

  // one-cycle commands from the controller to the datapath
  typedef struct packed {
    logic take;        // a word was accepted this cycle
    logic set_offset;
    logic rd;
    logic wr_one;
    logic wr_two;
    logic publish;
  } dbfr_cmd_t;

endpackage

FILE: rtl/dbfr_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module dbfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dbfr_ctrl.sv
`timescale 1ns / 1ps
// controller: accepts a word, decodes it into datapath commands, strobes the result
module dbfr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dbfr_pkg::OP_W-1:0] operation,
  output logic                      busy,
  output logic                      emit,
  output dbfr_pkg::dbfr_cmd_t       cmd
);
  import dbfr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_RESP);
  assign emit   = (state_r == ST_RESP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.take = accept;
    if (accept) begin
      unique case (operation)
        OP_SET_OFFSET: cmd.set_offset = 1'b1;
        OP_READ:       cmd.rd         = 1'b1;
        OP_WRITE_ONE:  cmd.wr_one     = 1'b1;
        OP_WRITE_TWO:  cmd.wr_two     = 1'b1;
        OP_PUBLISH:    cmd.publish    = 1'b1;
        default:       cmd.take       = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> $past(start) && !$past(busy))
    else $error("result strobe without an accepted word");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> !emit)
    else $error("result strobe longer than one cycle");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.set_offset, cmd.rd, cmd.wr_one, cmd.wr_two, cmd.publish}))
    else $error("more than one command at once");

endmodule

FILE: rtl/dbfr_dp.sv
`timescale 1ns / 1ps
// datapath: frame buffers, cursors, done marks and result registers
module dbfr_dp #(
  parameter int unsigned FRAME_ONE_BYTES = 22,
  parameter int unsigned FRAME_TWO_BYTES = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dbfr_pkg::dbfr_cmd_t         cmd,
  input  logic [dbfr_pkg::BYTE_W-1:0] byte_value,
  input  logic [dbfr_pkg::POS_W-1:0]  byte_position,
  output logic [dbfr_pkg::BYTE_W-1:0] read_byte,
  output logic                        read_valid,
  output logic                        accumulation_reset,
  output logic                        frame_one_done,
  output logic                        frame_two_done
);
  import dbfr_pkg::*;

  localparam int unsigned D1 = 2 * FRAME_ONE_BYTES;
  localparam int unsigned D2 = 2 * FRAME_TWO_BYTES;
  localparam int unsigned A1 = $clog2(D1);
  localparam int unsigned A2 = $clog2(D2);
  localparam logic [CUR_W-1:0] F1_C = CUR_W'(FRAME_ONE_BYTES);
  localparam logic [CUR_W-1:0] F2_C = CUR_W'(FRAME_TWO_BYTES);
  localparam logic [POS_W-1:0] F1_P = POS_W'(FRAME_ONE_BYTES);
  localparam logic [POS_W-1:0] F2_P = POS_W'(FRAME_TWO_BYTES);

  logic [CUR_W-1:0] cur1_r, cur1_nxt, cur2_r, cur2_nxt;
  logic             done1_r, done1_nxt, done2_r, done2_nxt;
  logic             pend_r, pend_nxt;
  logic             pub1_r, pub1_nxt, pub2_r, pub2_nxt;
  logic [D1-1:0]    vld1_r;
  logic [D2-1:0]    vld2_r;
  logic             hit1, hit2;

  logic             sel1_r, sel2_r, vq1_r, vq2_r, rv_r, acc_r;
  logic [A1-1:0]    raddr1, waddr1;
  logic [A2-1:0]    raddr2, waddr2;
  logic             we1, we2;
  logic [BYTE_W-1:0] q1, q2;

  assign hit1 = (cur1_r < F1_C);
  assign hit2 = !hit1 && (cur2_r < F2_C);

  // published half sits at offset pub * frame length, writes go to the other half
  assign raddr1 = A1'(cur1_r + (pub1_r ? F1_C : '0));
  assign raddr2 = A2'(cur2_r + (pub2_r ? F2_C : '0));
  assign waddr1 = A1'({1'b0, byte_position} + (pub1_r ? '0 : F1_C));
  assign waddr2 = A2'({1'b0, byte_position} + (pub2_r ? '0 : F2_C));
  assign we1    = cmd.wr_one && (byte_position < F1_P);
  assign we2    = cmd.wr_two && (byte_position < F2_P);

  dbfr_ram #(.WIDTH(BYTE_W), .DEPTH(D1)) u_ram_one (
    .clk(clk), .we(we1), .waddr(waddr1), .wdata(byte_value), .raddr(raddr1), .rdata(q1)
  );

  dbfr_ram #(.WIDTH(BYTE_W), .DEPTH(D2)) u_ram_two (
    .clk(clk), .we(we2), .waddr(waddr2), .wdata(byte_value), .raddr(raddr2), .rdata(q2)
  );

  always_comb begin
    cur1_nxt  = cur1_r;
    cur2_nxt  = cur2_r;
    done1_nxt = done1_r;
    done2_nxt = done2_r;
    pend_nxt  = pend_r;
    pub1_nxt  = pub1_r;
    pub2_nxt  = pub2_r;
    if (cmd.set_offset) begin
      cur1_nxt  = byte_value;
      cur2_nxt  = (byte_value > F1_C) ? byte_value - F1_C : '0;
      done1_nxt = 1'b0;
      done2_nxt = 1'b0;
    end
    if (cmd.rd) begin
      if (hit1) begin
        cur1_nxt = cur1_r + CUR_W'(1);
      end
      if (hit2) begin
        cur2_nxt = cur2_r + CUR_W'(1);
      end
      if (cur1_nxt >= F1_C - CUR_W'(1)) begin
        done1_nxt = 1'b1;
      end
      if (cur2_nxt >= F2_C - CUR_W'(1)) begin
        done2_nxt = 1'b1;
        pend_nxt  = 1'b1;
      end
    end
    if (cmd.publish) begin
      pend_nxt = 1'b0;
      if (done1_r) begin
        pub1_nxt = !pub1_r;
      end
      if (done2_r) begin
        pub2_nxt = !pub2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur1_r  <= '0;
      cur2_r  <= '0;
      done1_r <= 1'b1;
      done2_r <= 1'b1;
      pend_r  <= 1'b0;
      pub1_r  <= 1'b0;
      pub2_r  <= 1'b0;
      vld1_r  <= '0;
      vld2_r  <= '0;
    end else begin
      cur1_r  <= cur1_nxt;
      cur2_r  <= cur2_nxt;
      done1_r <= done1_nxt;
      done2_r <= done2_nxt;
      pend_r  <= pend_nxt;
      pub1_r  <= pub1_nxt;
      pub2_r  <= pub2_nxt;
      if (we1) begin
        vld1_r[waddr1] <= 1'b1;
      end
      if (we2) begin
        vld2_r[waddr2] <= 1'b1;
      end
    end
  end

  // result fields, captured with the ram read
  always_ff @(posedge clk) begin
    vq1_r <= vld1_r[raddr1];
    vq2_r <= vld2_r[raddr2];
    if (!rst_n) begin
      sel1_r <= 1'b0;
      sel2_r <= 1'b0;
      rv_r   <= 1'b0;
      acc_r  <= 1'b0;
    end else if (cmd.take) begin
      sel1_r <= cmd.rd && hit1;
      sel2_r <= cmd.rd && hit2;
      rv_r   <= cmd.rd;
      acc_r  <= cmd.publish && pend_r;
    end
  end

  always_comb begin
    read_byte = '0;
    if (sel1_r && vq1_r) begin
      read_byte = q1;
    end else if (sel2_r && vq2_r) begin
      read_byte = q2;
    end
  end

  assign read_valid         = rv_r;
  assign accumulation_reset = acc_r;
  assign frame_one_done     = done1_r;
  assign frame_two_done     = done2_r;

  a_cur2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.rd && !cmd.set_offset |=> $stable(cur2_r))
    else $error("frame two cursor moved without read or offset");
  a_publish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> !pend_r)
    else $error("pending accumulation reset survived publish");
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(sel1_r && sel2_r))
    else $error("read selected both frames");

endmodule

FILE: rtl/double_buffered_frame_readout.sv
`timescale 1ns / 1ps
// top level of the double-buffered frame readout
//
// Bus-target readout of two ping-pong frame buffers. Each accepted word
// (start high while busy is low) carries an operation: set the start
// offset, read the next byte, write a byte into the unpublished half of
// frame one or frame two, or publish. Every word produces exactly one
// result, shown on the out_ ports with out_strobe high for the one cycle
// right after the accepting edge, and taken at the edge that ends it: the
// word's state update and the buffer read are launched at the accepting
// edge, and the result comes out while the registered ram read returns.
// busy is high during that result cycle; no word is taken meanwhile.
// The receiver cannot stall: a result not taken in its strobe cycle is
// gone. Reads walk frame one and then frame two; past the end of frame
// two they return zero with out_read_valid still set. Publish swaps the
// halves of each frame whose readout-done mark is set and reports (then
// clears) the accumulation-reset flag raised by reading through frame
// two. Buffers read as zero until written; per-entry valid flops clear
// at reset, so there is no clearing pass and the block is ready at once.
module double_buffered_frame_readout #(
  parameter int unsigned FRAME_ONE_BYTES = 22,
  parameter int unsigned FRAME_TWO_BYTES = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  logic [dbfr_pkg::OP_W-1:0]   in_operation,
  input  logic [dbfr_pkg::BYTE_W-1:0] in_byte_value,
  input  logic [dbfr_pkg::POS_W-1:0]  in_byte_position,
  // result side, one word per strobe
  output logic                        out_strobe,
  output logic [dbfr_pkg::BYTE_W-1:0] out_read_byte,
  output logic                        out_read_valid,
  output logic                        out_accumulation_reset,
  output logic                        out_frame_one_done,
  output logic                        out_frame_two_done
);
  import dbfr_pkg::*;

  dbfr_cmd_t cmd;
  logic      emit;

  // decode and sequencing
  dbfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .busy      (busy),
    .emit      (emit),
    .cmd       (cmd)
  );

  // buffers, cursors and marks
  dbfr_dp #(
    .FRAME_ONE_BYTES (FRAME_ONE_BYTES),
    .FRAME_TWO_BYTES (FRAME_TWO_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .byte_value         (in_byte_value),
    .byte_position      (in_byte_position),
    .read_byte          (out_read_byte),
    .read_valid         (out_read_valid),
    .accumulation_reset (out_accumulation_reset),
    .frame_one_done     (out_frame_one_done),
    .frame_two_done     (out_frame_two_done)
  );

  assign out_strobe = emit;

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.take)
    else $error("word taken while busy");
  a_valid_only_with_strobe_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_read_valid |-> $past(in_operation) == OP_READ)
    else $error("read result for a non-read word");
  a_acc_only_on_publish: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_accumulation_reset |-> $past(in_operation) == OP_PUBLISH)
    else $error("accumulation reset outside publish");

endmodule

FILE: verif/tb_double_buffered_frame_readout.sv
`timescale 1ns / 1ps
// self-checking testbench for the double-buffered frame readout
module tb_double_buffered_frame_readout;
  import dbfr_pkg::*;

  // frame sizes, passed to the block so predictor and rtl agree
  localparam int F1 = 22;
  localparam int F2 = 25;

  // codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_WORDS   = 1400;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // one result word as the out_ ports show it
  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_valid;
    logic              acc_reset;
    logic              one_done;
    logic              two_done;
  } readout_t;

  // directed word, with a hand-written result where it is obvious
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] val;
    logic [POS_W-1:0]  pos;
    logic              typed;
    readout_t          want;
  } script_row_t;

  localparam readout_t NO_WANT = '0;
  localparam int SCRIPT_LEN = 25;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_operation;
  logic [BYTE_W-1:0] in_byte_value;
  logic [POS_W-1:0]  in_byte_position;
  logic              out_strobe;
  logic [BYTE_W-1:0] out_read_byte;
  logic              out_read_valid;
  logic              out_accumulation_reset;
  logic              out_frame_one_done;
  logic              out_frame_two_done;

  double_buffered_frame_readout #(
    .FRAME_ONE_BYTES(F1),
    .FRAME_TWO_BYTES(F2)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_byte_value         (in_byte_value),
    .in_byte_position      (in_byte_position),
    .out_strobe            (out_strobe),
    .out_read_byte         (out_read_byte),
    .out_read_valid        (out_read_valid),
    .out_accumulation_reset(out_accumulation_reset),
    .out_frame_one_done    (out_frame_one_done),
    .out_frame_two_done    (out_frame_two_done)
  );

  // shadow copy of the frame state
  logic [BYTE_W-1:0] f1_buf [2*F1];
  logic [BYTE_W-1:0] f2_buf [2*F2];
  logic              f1_half, f2_half;
  logic [CUR_W-1:0]  f1_cur, f2_cur;
  logic              f1_done, f2_done;
  logic              acc_pending;

  readout_t pending_readouts [$];
  int       mismatches;
  int       words_sent;
  int       idle_pct;
  int       quiet_cycles;

  // directed words: reset state, no-op codes, field extremes, ignored
  // out-of-range writes, a walk into and past the end of frame two,
  // and publish reporting then clearing the accumulation reset
  script_row_t script [SCRIPT_LEN] = '{
    '{OP_READ,       8'h00, 7'd0,   1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{OP_SPARE_5,    8'hff, 7'd127, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_PUBLISH,    8'h00, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_SPARE_7,    8'h00, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_WRITE_ONE,  8'hff, 7'd0,   1'b0, NO_WANT},
    '{OP_WRITE_ONE,  8'h80, 7'd21,  1'b0, NO_WANT},
    '{OP_WRITE_ONE,  8'haa, 7'd127, 1'b0, NO_WANT},
    '{OP_WRITE_TWO,  8'h01, 7'd0,   1'b0, NO_WANT},
    '{OP_WRITE_TWO,  8'h7f, 7'd24,  1'b0, NO_WANT},
    '{OP_WRITE_TWO,  8'h55, 7'd25,  1'b0, NO_WANT},
    '{OP_PUBLISH,    8'h00, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_SET_OFFSET, 8'h00, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_READ,       8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_SET_OFFSET, 8'd21, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_READ,       8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_SET_OFFSET, 8'd46, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_READ,       8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_READ,       8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_PUBLISH,    8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_PUBLISH,    8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_SET_OFFSET, 8'hff, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_READ,       8'h00, 7'd0,   1'b0, NO_WANT},
    '{OP_SPARE_6,    8'h5a, 7'd33,  1'b0, NO_WANT},
    '{OP_WRITE_ONE,  8'h00, 7'd64,  1'b0, NO_WANT},
    '{OP_SET_OFFSET, 8'd23, 7'd0,   1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b0}}
  };

  // free-running clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // next byte on the bus: frame one first, then frame two, zero past the end
  function automatic logic [BYTE_W-1:0] next_bus_byte();
    logic [BYTE_W-1:0] b;
    b = '0;
    if (f1_cur < F1) begin
      b = f1_buf[int'(f1_half) * F1 + int'(f1_cur)];
      f1_cur = f1_cur + 1'b1;
    end else if (f2_cur < F2) begin
      b = f2_buf[int'(f2_half) * F2 + int'(f2_cur)];
      f2_cur = f2_cur + 1'b1;
    end
    // the done test runs on every read, not only on the frame just read
    if (f1_cur >= F1 - 1) f1_done = 1'b1;
    if (f2_cur >= F2 - 1) begin
      f2_done     = 1'b1;
      acc_pending = 1'b1;
    end
    return b;
  endfunction

  // applies one accepted word to the shadow state, returns the result word
  function automatic readout_t frame_readout_step(logic [OP_W-1:0] op,
                                                  logic [BYTE_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
    readout_t r;
    r = '0;
    case (op)
      OP_SET_OFFSET: begin
        f1_cur  = val;
        f2_cur  = (val > F1) ? CUR_W'(val - F1) : '0;
        f1_done = 1'b0;
        f2_done = 1'b0;
      end
      OP_READ: begin
        r.rd_byte  = next_bus_byte();
        r.rd_valid = 1'b1;
      end
      // writes land in the unpublished half, out-of-range positions dropped
      OP_WRITE_ONE: if (pos < F1) f1_buf[int'(!f1_half) * F1 + int'(pos)] = val;
      OP_WRITE_TWO: if (pos < F2) f2_buf[int'(!f2_half) * F2 + int'(pos)] = val;
      OP_PUBLISH: begin
        r.acc_reset = acc_pending;
        acc_pending = 1'b0;
        if (f1_done) f1_half = !f1_half;
        if (f2_done) f2_half = !f2_half;
      end
      default: ;
    endcase
    r.one_done = f1_done;
    r.two_done = f2_done;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // drives one word from a falling edge and holds it until accepted;
  // the sender idles at random in front of it
  task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] val,
                           logic [POS_W-1:0] pos, logic typed, readout_t want);
    readout_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start            <= 1'b1;
    in_operation     <= op;
    in_byte_value    <= val;
    in_byte_position <= pos;
    do @(posedge clk); while (busy);
    // accepted at this edge: the shadow state always advances
    predicted = frame_readout_step(op, val, pos);
    pending_readouts.push_back(typed ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // sender idling by progress through the random part: 35 %, 59 %, none
  task automatic pick_idle_rate();
    if (words_sent < SCRIPT_LEN + RANDOM_WORDS / 3) idle_pct = 35;
    else if (words_sent < SCRIPT_LEN + 2 * RANDOM_WORDS / 3) idle_pct = 59;
    else idle_pct = 0;
  endtask

  task automatic send_plain(logic [OP_W-1:0] op, logic [BYTE_W-1:0] val,
                            logic [POS_W-1:0] pos);
    pick_idle_rate();
    send_word(op, val, pos, 1'b0, NO_WANT);
  endtask

  // a byte into either frame, mostly at a legal position
  task automatic send_frame_write();
    logic two;
    int   len;
    two = 1'($urandom_range(0, 1));
    len = two ? F2 : F1;
    send_plain(two ? OP_WRITE_TWO : OP_WRITE_ONE, BYTE_W'($urandom_range(0, 255)),
               POS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, len - 1)));
  endtask

  // well-formed transfer: position, fill the back halves, read out, publish
  task automatic run_frame_cycle();
    int sel, n_wr, n_rd;
    sel = $urandom_range(0, 9);
    if (sel < 6) send_plain(OP_SET_OFFSET, BYTE_W'($urandom_range(0, 4)),
                            POS_W'($urandom_range(0, 127)));
    else if (sel < 8) send_plain(OP_SET_OFFSET, BYTE_W'($urandom_range(F1 - 2, F1 + F2)),
                                 POS_W'($urandom_range(0, 127)));
    else if (sel < 9) send_plain(OP_SET_OFFSET, BYTE_W'($urandom_range(0, 255)),
                                 POS_W'($urandom_range(0, 127)));
    n_wr = $urandom_range(0, 12);
    repeat (n_wr) send_frame_write();
    n_rd = $urandom_range(5, F1 + F2 + 4);
    repeat (n_rd) begin
      if ($urandom_range(0, 99) < 15) send_frame_write();
      send_plain(OP_READ, BYTE_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 127)));
    end
    send_plain(OP_PUBLISH, BYTE_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 127)));
    if ($urandom_range(0, 4) == 0)
      send_plain(OP_PUBLISH, BYTE_W'($urandom_range(0, 255)),
                 POS_W'($urandom_range(0, 127)));
  endtask

  // checks every strobed result word against the oldest expectation
  always @(posedge clk) begin
    readout_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_read_byte, out_read_valid, out_accumulation_reset,
             out_frame_one_done, out_frame_two_done};
      if (pending_readouts.size() == 0) begin
        $display("[%0t] result word with nothing pending", $time);
        mismatches++;
      end else begin
        want = pending_readouts.pop_front();
        if (got.rd_byte !== want.rd_byte)
          report_mismatch("read_byte", int'(got.rd_byte), int'(want.rd_byte));
        if (got.rd_valid !== want.rd_valid)
          report_mismatch("read_valid", int'(got.rd_valid), int'(want.rd_valid));
        if (got.acc_reset !== want.acc_reset)
          report_mismatch("accumulation_reset", int'(got.acc_reset), int'(want.acc_reset));
        if (got.one_done !== want.one_done)
          report_mismatch("frame_one_done", int'(got.one_done), int'(want.one_done));
        if (got.two_done !== want.two_done)
          report_mismatch("frame_two_done", int'(got.two_done), int'(want.two_done));
      end
    end
  end

  // watchdog: too long without a word accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    start            = 1'b0;
    in_operation     = '0;
    in_byte_value    = '0;
    in_byte_position = '0;
    rst_n            = 1'b0;
    words_sent       = 0;
    idle_pct         = 35;
    // shadow state at reset: buffers zero, both frames marked read out
    foreach (f1_buf[i]) f1_buf[i] = '0;
    foreach (f2_buf[i]) f2_buf[i] = '0;
    f1_half     = 1'b0;
    f2_half     = 1'b0;
    f1_cur      = '0;
    f2_cur      = '0;
    f1_done     = 1'b1;
    f2_done     = 1'b1;
    acc_pending = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed script
    foreach (script[i])
      send_word(script[i].op, script[i].val, script[i].pos, script[i].typed, script[i].want);

    // random part: mostly whole transfers, some short bursts of noise
    while (words_sent < SCRIPT_LEN + RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) begin
        run_frame_cycle();
      end else begin
        repeat ($urandom_range(1, 8))
          send_plain(OP_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                     POS_W'($urandom_range(0, 127)));
      end
    end
    start <= 1'b0;

    // drain, then wait DRAIN_CYCLES more to catch stray strobes
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
